FILE: hdl/torus_grid_neighbour_map_macros.svh
// Assertion macros for the checker file of the neighbour map block.
`ifndef TORUS_GRID_NEIGHBOUR_MAP_MACROS_SVH
`define TORUS_GRID_NEIGHBOUR_MAP_MACROS_SVH

// Clocked assertion, quiet while rst_n is low.
`define TGNM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define TGNM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tgnm_pkg.sv
// Types, constants and shared helpers of the grid neighbour map.
package tgnm_pkg;

  localparam int unsigned MAX_FRAGMENTS_DEF = 256;

  localparam int unsigned IDX_W       = 8;   // fragment index
  localparam int unsigned ID_W        = 9;   // one-based ids
  localparam int unsigned DIM_W       = 16;  // lattice and tile sizes
  localparam int unsigned GRID_W      = 9;   // grid columns, rows, count
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PROD_W      = 2 * GRID_W;
  localparam int unsigned SUM_W       = PROD_W + 1;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_USED_W  = ID_W + 2 * DIM_W + 8 * ID_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LATTICE_WIDTH  = 3'd0,
    REG_LATTICE_HEIGHT = 3'd1,
    REG_GRID_COLUMNS   = 3'd2,
    REG_GRID_ROWS      = 3'd3,
    REG_FRAGMENT_COUNT = 3'd4,
    REG_TORUS_MODE     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_LOAD,
    SU_RUN
  } setup_state_t;

  // Grid geometry derived from the configuration registers.
  typedef struct packed {
    logic              torus;
    logic [GRID_W-1:0] cols;
    logic [GRID_W-1:0] rows;
    logic [DIM_W-1:0]  wq;
    logic [GRID_W-1:0] wr;
    logic [DIM_W-1:0]  hq;
    logic [GRID_W-1:0] hr;
  } geom_t;

  // One classified query, handed from the front to the back.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              hit;
    logic [GRID_W-1:0] row_up;
    logic [GRID_W-1:0] row_mid;
    logic [GRID_W-1:0] row_dn;
    logic              up_ok;
    logic              dn_ok;
    logic [GRID_W-1:0] col_l;
    logic [GRID_W-1:0] col_mid;
    logic [GRID_W-1:0] col_r;
    logic              l_ok;
    logic              r_ok;
  } job_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  // The remainder stays below the divisor.
  function automatic logic [GRID_W:0] div_step(input logic [GRID_W-1:0] rem,
                                                input logic              din,
                                                input logic [GRID_W-1:0] dvs);
    logic [GRID_W:0] trial;
    logic [GRID_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[GRID_W-1:0]};
    end else begin
      div_step = {1'b0, trial[GRID_W-1:0]};
    end
  endfunction

endpackage

FILE: hdl/tgnm_setup.sv
// Configuration registers and the dividers that derive tile sizes.
module tgnm_setup
  import tgnm_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
  parameter int unsigned LIM_W         = $clog2(MAX_FRAGMENTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output geom_t                 geom,
  output logic [LIM_W-1:0]      limit,
  output logic                  busy
);

  localparam int unsigned CNT_W = $clog2(DIM_W);
  localparam logic [PROD_W-1:0] MAX_L = PROD_W'(MAX_FRAGMENTS);

  logic [DIM_W-1:0]  lw_r, lh_r;
  logic [GRID_W-1:0] gc_r, gr_r, fc_r;
  logic              torus_r;

  setup_state_t      state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIM_W-1:0]  wsh_r, hsh_r;
  logic [GRID_W-1:0] wrem_r, hrem_r;
  logic [PROD_W-1:0] prod_r;
  logic [LIM_W-1:0]  limit_r, limit_nxt;

  logic [GRID_W-1:0] cols, rows;
  logic [GRID_W:0]   wstep, hstep;

  assign cols = (gc_r == '0) ? GRID_W'(1) : gc_r;
  assign rows = (gr_r == '0) ? GRID_W'(1) : gr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r    <= DIM_W'(1);
      lh_r    <= DIM_W'(1);
      gc_r    <= GRID_W'(1);
      gr_r    <= GRID_W'(1);
      fc_r    <= GRID_W'(1);
      torus_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LATTICE_WIDTH:  lw_r    <= cfg_wdata;
        REG_LATTICE_HEIGHT: lh_r    <= cfg_wdata;
        REG_GRID_COLUMNS:   gc_r    <= cfg_wdata[GRID_W-1:0];
        REG_GRID_ROWS:      gr_r    <= cfg_wdata[GRID_W-1:0];
        REG_FRAGMENT_COUNT: fc_r    <= cfg_wdata[GRID_W-1:0];
        REG_TORUS_MODE:     torus_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    case (state_r)
      SU_IDLE: begin
        busy = 1'b0;
      end
      SU_LOAD: begin
        state_nxt = SU_RUN;
      end
      SU_RUN: begin
        if (cnt_r == CNT_W'(DIM_W - 1)) begin
          state_nxt = SU_IDLE;
        end
      end
      default: begin
        state_nxt = SU_LOAD;
      end
    endcase
    // any register write restarts the derivation
    if (cfg_we) begin
      state_nxt = SU_LOAD;
    end
  end

  assign wstep = div_step(wrem_r, wsh_r[DIM_W-1], cols);
  assign hstep = div_step(hrem_r, hsh_r[DIM_W-1], rows);

  always_comb begin
    logic [PROD_W-1:0] lim;
    lim = prod_r;
    if (PROD_W'(fc_r) < lim) begin
      lim = PROD_W'(fc_r);
    end
    if (MAX_L < lim) begin
      lim = MAX_L;
    end
    limit_nxt = LIM_W'(lim);
  end

  // Both quotients shift in through the dividend registers, one bit a cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      SU_LOAD: begin
        wsh_r  <= lw_r;
        hsh_r  <= lh_r;
        wrem_r <= '0;
        hrem_r <= '0;
        cnt_r  <= '0;
        prod_r <= {{GRID_W{1'b0}}, cols} * {{GRID_W{1'b0}}, rows};
      end
      SU_RUN: begin
        wsh_r   <= {wsh_r[DIM_W-2:0], wstep[GRID_W]};
        hsh_r   <= {hsh_r[DIM_W-2:0], hstep[GRID_W]};
        wrem_r  <= wstep[GRID_W-1:0];
        hrem_r  <= hstep[GRID_W-1:0];
        cnt_r   <= cnt_r + CNT_W'(1);
        limit_r <= limit_nxt;
      end
      default: ;
    endcase
  end

  assign geom.torus = torus_r;
  assign geom.cols  = cols;
  assign geom.rows  = rows;
  assign geom.wq    = wsh_r;
  assign geom.wr    = wrem_r;
  assign geom.hq    = hsh_r;
  assign geom.hr    = hrem_r;
  assign limit      = limit_r;

endmodule

FILE: hdl/tgnm_front.sv
// Front end: accepts queries, splits the index into row and column, classifies edges.
module tgnm_front
  import tgnm_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
  parameter int unsigned LIM_W         = $clog2(MAX_FRAGMENTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IDX_W-1:0] in_idx,
  input  logic             busy,
  input  geom_t            geom,
  input  logic [LIM_W-1:0] limit,
  input  logic             q_full,
  output logic             push,
  output job_t             push_job
);

  typedef struct packed {
    logic [IDX_W-1:0]  dvd;
    logic [GRID_W-1:0] rem;
    logic [IDX_W-1:0]  quo;
    logic [ID_W-1:0]   id;
    logic              hit;
  } fst_t;

  logic [IDX_W:0] v_r;
  fst_t           st_r   [0:IDX_W];
  fst_t           st_nxt [0:IDX_W-1];
  fst_t           st0_nxt;
  logic           adv;

  // hold the whole divider only when its last stage cannot drain
  assign adv       = !(v_r[IDX_W] && q_full);
  assign in_tready = adv && !busy;

  always_comb begin
    st0_nxt.dvd = in_idx;
    st0_nxt.rem = '0;
    st0_nxt.quo = '0;
    st0_nxt.id  = {1'b0, in_idx} + ID_W'(1);
    st0_nxt.hit = PROD_W'(in_idx) < PROD_W'(limit);
  end

  always_comb begin
    for (int k = 0; k < IDX_W; k++) begin
      logic [GRID_W:0] d;
      d              = div_step(st_r[k].rem, st_r[k].dvd[IDX_W-1], geom.cols);
      st_nxt[k]      = st_r[k];
      st_nxt[k].dvd  = {st_r[k].dvd[IDX_W-2:0], 1'b0};
      st_nxt[k].quo  = {st_r[k].quo[IDX_W-2:0], d[GRID_W]};
      st_nxt[k].rem  = d[GRID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[IDX_W-1:0], in_tvalid && in_tready};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st0_nxt;
      for (int k = 1; k <= IDX_W; k++) begin
        st_r[k] <= st_nxt[k-1];
      end
    end
  end

  // Edge classification of the finished row and column.
  always_comb begin
    logic [GRID_W-1:0] row, col;
    row = {1'b0, st_r[IDX_W].quo};
    col = st_r[IDX_W].rem;

    push_job.id      = st_r[IDX_W].id;
    push_job.hit     = st_r[IDX_W].hit;
    push_job.row_mid = row;
    push_job.col_mid = col;

    if (row == '0) begin
      push_job.row_up = geom.rows - GRID_W'(1);
      push_job.up_ok  = geom.torus;
    end else begin
      push_job.row_up = row - GRID_W'(1);
      push_job.up_ok  = 1'b1;
    end
    if ({1'b0, row} + (GRID_W+1)'(1) >= {1'b0, geom.rows}) begin
      push_job.row_dn = '0;
      push_job.dn_ok  = geom.torus;
    end else begin
      push_job.row_dn = row + GRID_W'(1);
      push_job.dn_ok  = 1'b1;
    end

    if (col == '0) begin
      push_job.col_l = geom.cols - GRID_W'(1);
      push_job.l_ok  = geom.torus;
    end else begin
      push_job.col_l = col - GRID_W'(1);
      push_job.l_ok  = 1'b1;
    end
    if ({1'b0, col} + (GRID_W+1)'(1) >= {1'b0, geom.cols}) begin
      push_job.col_r = '0;
      push_job.r_ok  = geom.torus;
    end else begin
      push_job.col_r = col + GRID_W'(1);
      push_job.r_ok  = 1'b1;
    end
  end

  assign push = v_r[IDX_W] && !q_full;

endmodule

FILE: hdl/tgnm_queue.sv
// Short queue of classified queries between the front and the back.
module tgnm_queue
  import tgnm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic nempty,
  output job_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             ent_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full   = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign nempty = cnt_r != '0;
  assign head   = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/tgnm_back.sv
// Back end: forms neighbour ids and tile sizes and holds the result beat.
module tgnm_back
  import tgnm_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
  parameter int unsigned LIM_W         = $clog2(MAX_FRAGMENTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_nempty,
  input  job_t                   q_head,
  output logic                   pop,
  input  geom_t                  geom,
  input  logic [LIM_W-1:0]       limit,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   v1_r;
  job_t                   job_r;
  logic [PROD_W-1:0]      p_up_r, p_mid_r, p_dn_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                   adv;

  function automatic logic [ID_W-1:0] nb_id(input logic [PROD_W-1:0] base,
                                            input logic [GRID_W-1:0] col,
                                            input logic              ok,
                                            input logic [LIM_W-1:0]  lim);
    logic [SUM_W-1:0] idx;
    logic [SUM_W-1:0] nxt;
    idx = SUM_W'(base) + SUM_W'(col);
    nxt = idx + SUM_W'(1);
    if (!ok || idx >= SUM_W'(lim)) begin
      nb_id = '0;
    end else begin
      nb_id = nxt[ID_W-1:0];
    end
  endfunction

  assign adv = !out_valid_r || out_tready;
  assign pop = q_nempty && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_nempty;
      out_valid_r <= v1_r;
    end
  end

  // Row base offsets; the column is added one stage later.
  always_ff @(posedge clk) begin
    if (adv) begin
      job_r   <= q_head;
      p_up_r  <= {{GRID_W{1'b0}}, q_head.row_up}  * {{GRID_W{1'b0}}, geom.cols};
      p_mid_r <= {{GRID_W{1'b0}}, q_head.row_mid} * {{GRID_W{1'b0}}, geom.cols};
      p_dn_r  <= {{GRID_W{1'b0}}, q_head.row_dn}  * {{GRID_W{1'b0}}, geom.cols};
      out_data_r <= out_data_nxt;
    end
  end

  always_comb begin
    logic [DIM_W-1:0] tw, th;
    logic [ID_W-1:0]  ul, up, ur, rt, dr, dn, dl, lt;
    tw = geom.wq + DIM_W'(job_r.col_mid < geom.wr);
    th = geom.hq + DIM_W'(job_r.row_mid < geom.hr);
    ul = nb_id(p_up_r,  job_r.col_l,   job_r.up_ok && job_r.l_ok, limit);
    up = nb_id(p_up_r,  job_r.col_mid, job_r.up_ok,               limit);
    ur = nb_id(p_up_r,  job_r.col_r,   job_r.up_ok && job_r.r_ok, limit);
    rt = nb_id(p_mid_r, job_r.col_r,   job_r.r_ok,                limit);
    dr = nb_id(p_dn_r,  job_r.col_r,   job_r.dn_ok && job_r.r_ok, limit);
    dn = nb_id(p_dn_r,  job_r.col_mid, job_r.dn_ok,               limit);
    dl = nb_id(p_dn_r,  job_r.col_l,   job_r.dn_ok && job_r.l_ok, limit);
    lt = nb_id(p_mid_r, job_r.col_l,   job_r.l_ok,                limit);
    // out-of-range query: only the id survives
    if (!job_r.hit) begin
      tw = '0;
      th = '0;
      ul = '0;
      up = '0;
      ur = '0;
      rt = '0;
      dr = '0;
      dn = '0;
      dl = '0;
      lt = '0;
    end
    out_data_nxt = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                    lt, dl, dn, dr, rt, ur, up, ul, th, tw, job_r.id};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hdl/torus_grid_neighbour_map.sv
// Top level of the grid neighbour map: streams queries in, neighbour records out.
//
// Input channel (in_*): one beat carries a zero-based fragment index.
// Output channel (out_*): one beat per query with the fragment id, its tile
//   width and height, and the ids of its eight neighbours clockwise from
//   upper-left (0 where a neighbour is absent or out of range).
// Configuration (cfg_*): write-only registers; the user writes them only while no
// query is open, and the block itself does not enforce this.
// A query passes through an 8-stage restoring divider that splits the index into
// row and column; a short queue decouples it from the back end, which forms the
// row offsets in one stage and the ids in the output register. One query is
// accepted per cycle while the front is not held by a full queue and the tile-size
// divider is not busy.
// After reset and after every register write the tile-size divider makes one load
// step, then one quotient bit per cycle; in_tready stays low during that pass.
// When the receiver stalls, the output beat holds, the queue fills (4 entries)
// and only then does in_tready drop.
module torus_grid_neighbour_map
  import tgnm_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] fragment_index
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [8:0] fragment_id, [24:9] tile_width, [40:25] tile_height,
  // [49:41] up_left_id, [58:50] up_id, [67:59] up_right_id, [76:68] right_id,
  // [85:77] down_right_id, [94:86] down_id, [103:95] down_left_id,
  // [112:104] left_id, [119:113] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned LIM_W = $clog2(MAX_FRAGMENTS + 1);

  geom_t            geom;
  logic [LIM_W-1:0] limit;
  logic             busy;
  logic             q_full, q_nempty, push, pop;
  job_t             push_job, q_head;

  tgnm_setup #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .LIM_W         (LIM_W)
  ) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .limit     (limit),
    .busy      (busy)
  );

  tgnm_front #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .LIM_W         (LIM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_idx    (in_tdata[IDX_W-1:0]),
    .busy      (busy),
    .geom      (geom),
    .limit     (limit),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  tgnm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head     (q_head)
  );

  tgnm_back #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .LIM_W         (LIM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nempty   (q_nempty),
    .q_head     (q_head),
    .pop        (pop),
    .geom       (geom),
    .limit      (limit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hdl/tgnm_checker.sv
// Port-level checks of the grid neighbour map and their bind to the top level.
`include "torus_grid_neighbour_map_macros.svh"

module tgnm_checker
  import tgnm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_we
);

  `TGNM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `TGNM_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0, "padding bits set")
  `TGNM_ASSERT(a_id_nonzero, out_tvalid |-> out_tdata[ID_W-1:0] != '0, "fragment id of zero")
  `TGNM_ASSERT(a_cfg_stalls_in, cfg_we |=> !in_tready, "input taken right after a register write")
  `TGNM_ASSERT_RST(a_reset_quiet, !rst_n |=> !in_tready && !out_tvalid, "channels active after reset")

endmodule

bind torus_grid_neighbour_map tgnm_checker u_tgnm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we)
);

FILE: test/tb_torus_grid_neighbour_map.sv
// Self-checking testbench for the grid neighbour map: directed and random queries checked against a model.
module tb_torus_grid_neighbour_map
  import tgnm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One output beat, fields from the highest bit down; nbr[0] is upper-left,
  // then clockwise to nbr[7], the left neighbour.
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_USED_W-1:0] pad;
    logic [7:0][ID_W-1:0]              nbr;
    logic [DIM_W-1:0]                  th;
    logic [DIM_W-1:0]                  tw;
    logic [ID_W-1:0]                   id;
  } neighbour_rec_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies, reset values.
  logic [DIM_W-1:0]  lat_w = 16'd1;
  logic [DIM_W-1:0]  lat_h = 16'd1;
  logic [GRID_W-1:0] grid_cols = 9'd1;
  logic [GRID_W-1:0] grid_rows = 9'd1;
  logic [GRID_W-1:0] frag_count = 9'd1;
  logic              torus_on = 1'b0;

  logic [IDX_W-1:0] query_queue[$];
  neighbour_rec_t   expected_recs[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      mismatches = 0;

  torus_grid_neighbour_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Number of valid fragments under the current registers.
  function automatic int unsigned fragment_limit();
    int unsigned cols;
    int unsigned rows;
    int unsigned lim;
    cols = (grid_cols == 0) ? 1 : grid_cols;
    rows = (grid_rows == 0) ? 1 : grid_rows;
    lim = cols * rows;
    if (frag_count < lim) lim = frag_count;
    if (lim > MAX_FRAGMENTS_DEF) lim = MAX_FRAGMENTS_DEF;
    return lim;
  endfunction

  function automatic neighbour_rec_t predict_neighbours(input logic [IDX_W-1:0] index);
    neighbour_rec_t rec;
    int unsigned    cols;
    int unsigned    rows;
    int unsigned    lim;
    int unsigned    row;
    int unsigned    col;
    int unsigned    r;
    int unsigned    c;
    int unsigned    n;
    int             dr;
    int             dc;
    logic           present;
    rec = '0;
    cols = (grid_cols == 0) ? 1 : grid_cols;
    rows = (grid_rows == 0) ? 1 : grid_rows;
    lim = fragment_limit();
    rec.id = index + 9'd1;
    if (index >= lim) return rec;
    row = index / cols;
    col = index % cols;
    rec.tw = DIM_W'(lat_w / cols + ((col < lat_w % cols) ? 1 : 0));
    rec.th = DIM_W'(lat_h / rows + ((row < lat_h % rows) ? 1 : 0));
    for (int k = 0; k < 8; k++) begin
      dr = (k < 3) ? -1 : ((k == 3 || k == 7) ? 0 : 1);
      dc = (k == 0 || k >= 6) ? -1 : ((k == 1 || k == 5) ? 0 : 1);
      present = 1'b1;
      r = row;
      c = col;
      // Step off an edge: wrap in torus mode, drop the neighbour otherwise.
      if (dr < 0) begin
        if (row == 0) begin
          present = torus_on;
          r = rows - 1;
        end else begin
          r = row - 1;
        end
      end else if (dr > 0) begin
        if (row + 1 >= rows) begin
          present = torus_on;
          r = 0;
        end else begin
          r = row + 1;
        end
      end
      if (dc < 0) begin
        if (col == 0) begin
          present = present & torus_on;
          c = cols - 1;
        end else begin
          c = col - 1;
        end
      end else if (dc > 0) begin
        if (col + 1 >= cols) begin
          present = present & torus_on;
          c = 0;
        end else begin
          c = col + 1;
        end
      end
      n = r * cols + c;
      if (present && n < lim) rec.nbr[k] = ID_W'(n + 1);
    end
    return rec;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Driver: record accepted beats, then load the next pending query.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_recs.push_back(predict_neighbours(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (query_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= query_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every output beat with the oldest prediction.
  always @(posedge clk) begin : monitor_blk
    neighbour_rec_t got;
    neighbour_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = neighbour_rec_t'(out_tdata);
        if (expected_recs.size() == 0) begin
          report_mismatch($sformatf("output beat with no query pending, id %0d", got.id));
        end else begin
          want = expected_recs.pop_front();
          if (got.id !== want.id)
            report_mismatch($sformatf("fragment_id: got %0d, want %0d", got.id, want.id));
          if (got.tw !== want.tw)
            report_mismatch($sformatf("id %0d tile_width: got %0d, want %0d",
                                      want.id, got.tw, want.tw));
          if (got.th !== want.th)
            report_mismatch($sformatf("id %0d tile_height: got %0d, want %0d",
                                      want.id, got.th, want.th));
          for (int k = 0; k < 8; k++) begin
            if (got.nbr[k] !== want.nbr[k])
              report_mismatch($sformatf("id %0d neighbour %0d: got %0d, want %0d",
                                        want.id, k, got.nbr[k], want.nbr[k]));
          end
          if (got.pad !== '0)
            report_mismatch($sformatf("id %0d padding bits not zero: %h", want.id, got.pad));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold until every query is sent and answered, then let the pipeline settle.
  // Check at the falling edge, once the driver's updates have landed.
  task automatic drain();
    while (query_queue.size() > 0 || in_tvalid || expected_recs.size() > 0)
      @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Call at a rising edge; leaves the write enable high for the next write.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_LATTICE_WIDTH:  lat_w = value;
      REG_LATTICE_HEIGHT: lat_h = value;
      REG_GRID_COLUMNS:   grid_cols = value[GRID_W-1:0];
      REG_GRID_ROWS:      grid_rows = value[GRID_W-1:0];
      REG_FRAGMENT_COUNT: frag_count = value[GRID_W-1:0];
      REG_TORUS_MODE:     torus_on = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned lw, input int unsigned lh, input int unsigned cols,
                          input int unsigned rows, input int unsigned frags,
                          input int unsigned torus);
    drain();
    write_reg(REG_LATTICE_WIDTH, CFG_DATA_W'(lw));
    write_reg(REG_LATTICE_HEIGHT, CFG_DATA_W'(lh));
    write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(cols));
    write_reg(REG_GRID_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_FRAGMENT_COUNT, CFG_DATA_W'(frags));
    write_reg(REG_TORUS_MODE, CFG_DATA_W'(torus));
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned pick_grid_dim();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return 256;
      3:       return $urandom_range(511);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  initial begin
    int unsigned cols;
    int unsigned rows;
    int unsigned eff;
    int unsigned frags;
    int unsigned lim;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: a single fragment, everything else out of range.
    query_queue = '{8'd0, 8'd1, 8'd255};
    // Full 16 x 16 torus at the largest lattice: corners wrap.
    set_grid(65535, 65535, 16, 16, 256, 1);
    query_queue = '{8'd0, 8'd15, 8'd240, 8'd255, 8'd17};
    // Same grid as a mesh: edge neighbours drop out.
    set_grid(65535, 65535, 16, 16, 256, 0);
    query_queue = '{8'd0, 8'd15, 8'd240, 8'd255};
    // Zero columns and rows act as one; empty lattice gives zero-width tiles.
    set_grid(0, 7, 0, 0, 1, 1);
    query_queue = '{8'd0, 8'd1};
    // Oversized grid clipped at the fragment maximum, lattice smaller than grid.
    set_grid(100, 3, 511, 511, 511, 1);
    query_queue = '{8'd0, 8'd255, 8'd254, 8'd99, 8'd100};
    // Fragment count below columns times rows.
    set_grid(12, 9, 5, 4, 17, 0);
    query_queue = '{8'd16, 8'd17, 8'd11, 8'd19};

    for (int p = 0; p < 8; p++) begin
      cols = pick_grid_dim();
      rows = pick_grid_dim();
      eff = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows);
      frags = ($urandom_range(3) == 0) ? $urandom_range(511) : ((eff > 256) ? 256 : eff);
      set_grid(($urandom_range(4) == 0) ? $urandom_range(cols) : $urandom_range(65535),
               ($urandom_range(4) == 0) ? $urandom_range(rows) : $urandom_range(65535),
               cols, rows, frags, $urandom_range(1));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      lim = fragment_limit();
      for (int i = 0; i < 115; i++) begin
        // Pause the sender halfway until every answer is back.
        if (i == 57) drain();
        if (lim > 0 && $urandom_range(4) != 0)
          query_queue.push_back(IDX_W'($urandom_range(lim - 1)));
        else
          query_queue.push_back(IDX_W'($urandom_range(255)));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: torus_grid_neighbour_map.f
+incdir+hdl
hdl/tgnm_pkg.sv
hdl/tgnm_setup.sv
hdl/tgnm_front.sv
hdl/tgnm_queue.sv
hdl/tgnm_back.sv
hdl/torus_grid_neighbour_map.sv
hdl/tgnm_checker.sv
test/tb_torus_grid_neighbour_map.sv
